[rtl/clock_frequency_calibrator_unit_defines.svh]
// Assertion macros shared by the calibrator RTL.
// Needs nothing else. The asserting modules include it by file name.
`ifndef CLOCK_FREQUENCY_CALIBRATOR_UNIT_DEFINES_SVH
`define CLOCK_FREQUENCY_CALIBRATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define CFCAL_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define CFCAL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cfcal_pkg.sv]
// Calibrator package: constants, reciprocal multipliers and shared types.
// Has no dependencies. The top level, tracker and pulse unit refer to it by scoped names.
package cfcal_pkg;

  // Accepted count window (both bounds excluded)
  localparam logic [15:0] COUNT_LOW_EXCL  = 16'd14843;
  localparam logic [15:0] COUNT_HIGH_EXCL = 16'd16406;
  localparam logic [15:0] LOCK_TOLERANCE  = 16'd15;

  // Sample counter landmarks
  localparam logic [4:0] INDEX_FULL   = 5'd30;
  localparam logic [4:0] INDEX_LOCKED = 5'd10;

  // Reset estimate: 16 MHz, so count 16000000 >> 10 and coefficient 16000000 / 1600
  localparam logic [15:0] EMU_RESET  = 16'd15625;
  localparam logic [15:0] COEF_RESET = 16'd10000;

  // floor(t / 5) = (t * DIV5_MUL) >> DIV5_SHIFT for t < 2^18
  localparam logic [18:0] DIV5_MUL   = 19'd419431;
  localparam int          DIV5_SHIFT = 21;

  // floor(4s / 125) = (s * DIV125_MUL) >> DIV125_SHIFT for s < 2^20
  localparam logic [22:0] DIV125_MUL   = 23'd4294968;
  localparam int          DIV125_SHIFT = 27;

  // floor(8p / 25) = (p * DIV25_MUL) >> DIV25_SHIFT for p < 2^17
  localparam logic [20:0] DIV25_MUL   = 21'd1342178;
  localparam int          DIV25_SHIFT = 22;

  // floor(w / 625) = (w * DIV625_MUL) >> DIV625_SHIFT for w < 2^28
  localparam logic [28:0] DIV625_MUL   = 29'd439804652;
  localparam int          DIV625_SHIFT = 38;

  // floor(x / 3125) = (x * DIV3125_MUL) >> DIV3125_SHIFT for x < 2^26
  localparam logic [26:0] DIV3125_MUL   = 27'd87960931;
  localparam int          DIV3125_SHIFT = 38;

  // Frequency view handed from the tracker to the pipeline
  typedef struct packed {
    logic [15:0] emu;
    logic [15:0] coef;
  } trk_val_t;

  // Pipeline control for the pulse unit
  typedef struct packed {
    logic load;    // stage 1 transaction moves on
    logic commit;  // stage 2 transaction moves to the result register
    logic func;    // selector of the stage 1 transaction
  } pulse_ctl_t;

endpackage

[rtl/cfcal_if.sv]
// Valid/ready stream interfaces for calibrator input and result transactions.
// Has no dependencies.
interface cfcal_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic        [15:0] osc_count;
  logic signed [11:0] ppm_tenths;

  modport source(output valid, func, osc_count, ppm_tenths, input ready);
  modport sink(input valid, func, osc_count, ppm_tenths, output ready);
endinterface

interface cfcal_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] emu_count;
  logic [15:0] freq_coef_out;
  logic [15:0] pulse_coef;

  modport source(output valid, emu_count, freq_coef_out, pulse_coef, input ready);
  modport sink(input valid, emu_count, freq_coef_out, pulse_coef, output ready);
endinterface

[rtl/clock_frequency_calibrator_unit.sv]
// Clock frequency calibrator, top level. A result passes through the input register,
// the product stage and the result register, and is valid once it reaches the result
// register. Throughput: one transaction per cycle unless result.ready stalls the pipeline;
// the two-stage multiply-by-reciprocal path of the pulse coefficient sets the depth.
// Reset (synchronous, active high) empties the pipeline, restores the 16 MHz
// estimate with coefficient 10000, and clears the pulse and nominal registers.
`include "clock_frequency_calibrator_unit_defines.svh"

module clock_frequency_calibrator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  cfcal_in_if.sink    item,
  cfcal_out_if.source result
);

  logic [15:0]        nominal;

  logic               s1_valid;
  logic               s1_func;
  logic [15:0]        s1_osc;
  logic signed [11:0] s1_ppm;

  logic               s2_valid;
  logic [15:0]        s2_emu;
  logic [15:0]        s2_coef;

  logic               out_valid;
  logic [15:0]        out_emu;
  logic [15:0]        out_coef;

  logic               out_free, s2_free, s1_free, s2_move, s1_move;
  logic [15:0]        freq_coef;
  logic [15:0]        pulse_coef;
  cfcal_pkg::trk_val_t  trk_next;
  cfcal_pkg::pulse_ctl_t pctl;

  // Pipeline advance: each stage moves when the one after it has room
  always_comb begin
    out_free = !out_valid || result.ready;
    s2_move  = s2_valid && out_free;
    s2_free  = !s2_valid || out_free;
    s1_move  = s1_valid && s2_free;
    s1_free  = !s1_valid || s2_free;
  end

  assign item.ready = s1_free;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      nominal <= 16'd0;
    end else if (cfg_we) begin
      nominal <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && item.valid) begin
      s1_func <= item.func;
      s1_osc  <= item.osc_count;
      s1_ppm  <= item.ppm_tenths;
    end
  end

  cfcal_track u_track (
    .clk       (clk),
    .rst       (rst),
    .en        (s1_move && !s1_func),
    .osc_count (s1_osc),
    .freq_coef (freq_coef),
    .nxt       (trk_next)
  );

  always_comb begin
    pctl.load   = s1_move;
    pctl.commit = s2_move;
    pctl.func   = s1_func;
  end

  cfcal_pulse u_pulse (
    .clk            (clk),
    .rst            (rst),
    .ctl            (pctl),
    .nominal        (nominal),
    .freq_coef      (freq_coef),
    .ppm_tenths     (s1_ppm),
    .pulse_coef_reg (pulse_coef)
  );

  // Stage 2: frequency view after this transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_emu  <= trk_next.emu;
      s2_coef <= trk_next.coef;
    end
  end

  // Result register; the pulse coefficient register takes a ppm result on the same move
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_emu  <= s2_emu;
      out_coef <= s2_coef;
    end
  end

  assign result.valid         = out_valid;
  assign result.emu_count     = out_emu;
  assign result.freq_coef_out = out_coef;
  assign result.pulse_coef    = pulse_coef;

  `CFCAL_ASSERT_IMPLIES(a_full_blocks_input, clk, rst, s1_valid && s2_valid && out_valid && !result.ready, !item.ready, "input taken while the pipeline is full and stalled")
  `CFCAL_ASSERT_NEXT(a_stage2_delivers, clk, rst, s2_move, result.valid, "stage 2 transaction lost on its way to the result")

endmodule

[rtl/cfcal_track.sv]
// Oscillator sample tracker: window check, averaging, fast lock, frequency state.
// Depends on cfcal_pkg and the assertion macros header.
`include "clock_frequency_calibrator_unit_defines.svh"

module cfcal_track (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [15:0]         osc_count,
  output logic [15:0]         freq_coef,
  output cfcal_pkg::trk_val_t nxt
);

  logic [4:0]  sample_index, sample_index_next;
  logic [19:0] count_sum, count_sum_next;
  logic [15:0] prev_count, prev_count_next;
  logic [15:0] emu, emu_next;
  logic [15:0] freq_coef_next;

  logic        in_range;
  logic        full;
  logic        near;
  logic [19:0] sum_add;
  logic [4:0]  idx_inc;
  logic [16:0] pair_sum;
  logic [15:0] diff;
  logic [36:0] emu_full_prod;
  logic [42:0] coef_full_prod;
  logic [37:0] coef_fast_prod;

  // Candidate values for a sample in the window
  always_comb begin
    in_range = (osc_count > cfcal_pkg::COUNT_LOW_EXCL) &&
               (osc_count < cfcal_pkg::COUNT_HIGH_EXCL);
    sum_add  = count_sum + {4'd0, osc_count};
    idx_inc  = sample_index + 5'd1;
    full     = (idx_inc >= cfcal_pkg::INDEX_FULL);
    pair_sum = {1'b0, prev_count} + {1'b0, osc_count};
    diff     = (prev_count >= osc_count) ? (prev_count - osc_count)
                                         : (osc_count - prev_count);
    near     = (diff < cfcal_pkg::LOCK_TOLERANCE);
  end

  // Averaged estimate: count = sum / 20, coefficient = 4 * sum / 125
  assign emu_full_prod  = 37'(sum_add[19:2]) * 37'(cfcal_pkg::DIV5_MUL);
  assign coef_full_prod = 43'(sum_add) * 43'(cfcal_pkg::DIV125_MUL);

  // Fast lock estimate: count = pair / 2, coefficient = 8 * pair / 25
  assign coef_fast_prod = 38'(pair_sum) * 38'(cfcal_pkg::DIV25_MUL);

  // Next state for one sample transaction
  always_comb begin
    sample_index_next = sample_index;
    count_sum_next    = count_sum;
    prev_count_next   = prev_count;
    emu_next          = emu;
    freq_coef_next    = freq_coef;
    if (en && in_range) begin
      count_sum_next    = sum_add;
      sample_index_next = idx_inc;
      if (full) begin
        sample_index_next = cfcal_pkg::INDEX_LOCKED;
        emu_next          = emu_full_prod[cfcal_pkg::DIV5_SHIFT +: 16];
        freq_coef_next    = coef_full_prod[cfcal_pkg::DIV125_SHIFT +: 16];
        count_sum_next    = 20'd0;
      end else if (idx_inc < cfcal_pkg::INDEX_LOCKED) begin
        if (near) begin
          sample_index_next = cfcal_pkg::INDEX_LOCKED;
          emu_next          = pair_sum[16:1];
          freq_coef_next    = coef_fast_prod[cfcal_pkg::DIV25_SHIFT +: 16];
          count_sum_next    = 20'd0;
        end
        prev_count_next = osc_count;
      end
    end
  end

  assign nxt.emu  = emu_next;
  assign nxt.coef = freq_coef_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= 5'd0;
      count_sum    <= 20'd0;
      prev_count   <= 16'd0;
      emu          <= cfcal_pkg::EMU_RESET;
      freq_coef    <= cfcal_pkg::COEF_RESET;
    end else begin
      sample_index <= sample_index_next;
      count_sum    <= count_sum_next;
      prev_count   <= prev_count_next;
      emu          <= emu_next;
      freq_coef    <= freq_coef_next;
    end
  end

  `CFCAL_ASSERT_NEXT(a_full_restarts, clk, rst, en && in_range && full, sample_index == cfcal_pkg::INDEX_LOCKED && count_sum == 20'd0, "averaging did not restart at the locked index")
  `CFCAL_ASSERT_NEXT(a_idle_holds_freq, clk, rst, !en, $stable(emu) && $stable(freq_coef), "frequency state moved without a sample")

endmodule

[rtl/cfcal_pulse.sv]
// Pulse coefficient unit: products in stage 1, constant division and sum in stage 2.
// Depends on cfcal_pkg and the assertion macros header.
`include "clock_frequency_calibrator_unit_defines.svh"

module cfcal_pulse (
  input  logic                  clk,
  input  logic                  rst,
  input  cfcal_pkg::pulse_ctl_t ctl,
  input  logic [15:0]           nominal,
  input  logic [15:0]           freq_coef,
  input  logic signed [11:0]    ppm_tenths,
  output logic [15:0]           pulse_coef_reg
);

  logic        s2_func;
  logic [31:0] nom_prod;
  logic [26:0] ppm_prod;
  logic        ppm_neg;

  logic [11:0] ppm_mag;
  logic [27:0] ppm_prod_full;
  logic [56:0] q1_prod;
  logic [52:0] q2_prod;
  logic [15:0] q2_mag;
  logic [15:0] q2_signed;
  logic [15:0] pulse_calc;

  // Stage 1: magnitude of the correction and both products
  assign ppm_mag       = ppm_tenths[11] ? (~ppm_tenths + 12'd1) : ppm_tenths;
  assign ppm_prod_full = 28'(ppm_mag) * 28'(freq_coef);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      nom_prod <= 32'(nominal) * 32'(freq_coef);
      ppm_prod <= ppm_prod_full[26:0];
      ppm_neg  <= ppm_tenths[11];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_func <= 1'b0;
    end else if (ctl.load) begin
      s2_func <= ctl.func;
    end
  end

  // Stage 2: nominal / 10000 and correction / 6250, truncated toward zero
  assign q1_prod   = 57'(nom_prod[31:4]) * 57'(cfcal_pkg::DIV625_MUL);
  assign q2_prod   = 53'(ppm_prod[26:1]) * 53'(cfcal_pkg::DIV3125_MUL);
  assign q2_mag    = {1'b0, q2_prod[cfcal_pkg::DIV3125_SHIFT +: 15]};
  assign q2_signed = ppm_neg ? (~q2_mag + 16'd1) : q2_mag;
  assign pulse_calc = q1_prod[cfcal_pkg::DIV625_SHIFT +: 16] + q2_signed;

  // Update the coefficient when a ppm transaction leaves stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_coef_reg <= 16'd0;
    end else if (ctl.commit && s2_func) begin
      pulse_coef_reg <= pulse_calc;
    end
  end

  `CFCAL_ASSERT_NEXT(a_pulse_holds, clk, rst, !(ctl.commit && s2_func), $stable(pulse_coef_reg), "pulse coefficient moved without a ppm update")

endmodule
